@@ src/hsl_to_rgb_converter_core_defines.svh @@
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on clk_i, muted while rst_ni is low
`define H2R_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsl_to_rgb_converter_core: assertion failed");
// Check a property on clk_i through reset as well
`define H2R_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hsl_to_rgb_converter_core: reset assertion failed");
`else
`define H2R_ASSERT(lbl, prop)
`define H2R_ASSERT_RST(lbl, prop)
`endif

`endif

@@ src/hsl2rgb_pkg.sv @@
// Types, widths and constants shared by the HSL to RGB converter stages.
package hsl2rgb_pkg;

  // Field widths
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned LEVEL_W = 8;

  // Q16 values in [0, 1.0] need one integer bit
  localparam int unsigned Q_W = 17;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  // Hue divide by 60 << frac bits is done as (hue << (14 - frac)) / 15.
  // Widths are sized for the smallest fraction setting (widest numerator).
  localparam int unsigned HUE_SHIFT_BASE = 14;
  localparam int unsigned NUM_W          = HUE_W + HUE_SHIFT_BASE;
  localparam int unsigned RECIP_SHIFT    = 32;
  localparam int unsigned RECIP_W        = 29;
  localparam logic [RECIP_W-1:0] RECIP_15 = 29'h11111111;  // floor(2^32 / 15)
  localparam int unsigned PROD_W         = NUM_W + RECIP_W;
  localparam int unsigned HQ_W           = PROD_W - RECIP_SHIFT;
  localparam int unsigned HUE_DIVISOR    = 15;

  // Sector of the hue circle, each 60 degrees wide
  localparam int unsigned SECTOR_COUNT = 6;
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Stage 1: lightness, saturation, chroma factor, hue reciprocal product
  typedef struct packed {
    logic [Q_W-1:0]    lq;
    logic [Q_W-1:0]    sq;
    logic [Q_W-1:0]    tq;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
  } s1_t;

  // Stage 2: chroma and hue in sectors (Q16)
  typedef struct packed {
    logic [Q_W-1:0]  lq;
    logic [Q_W-1:0]  cq;
    logic [HQ_W-1:0] hq;
  } s2_t;

  // Stage 3: channel terms and sector
  typedef struct packed {
    logic [Q_W-1:0] cq;
    logic [Q_W-1:0] xq;
    logic [Q_W-1:0] mq;
    sector_e        sector;
  } s3_t;

endpackage

@@ src/hsl2rgb_front.sv @@
// Stage 1: Q16 conversion of lightness and saturation, hue reciprocal multiply.
module hsl2rgb_front import hsl2rgb_pkg::*; #(
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [HUE_W-1:0]   hue_angle_i,
  input  logic [LEVEL_W-1:0] saturation_i,
  input  logic [LEVEL_W-1:0] lightness_i,
  output s1_t                s1_o
);

  localparam int unsigned HueShift = HUE_SHIFT_BASE - HUE_FRACTION_BITS;
  localparam logic [Q_W:0] OneWide = {1'b0, ONE_Q16};

  // x * 65536 / 255 rounded down equals x * 257, plus one at full scale
  function automatic logic [Q_W-1:0] to_q16(input logic [LEVEL_W-1:0] x);
    logic [Q_W-1:0] rep;
    rep = {1'b0, x, x};
    return rep + Q_W'(x == {LEVEL_W{1'b1}});
  endfunction

  logic [Q_W-1:0] lq, sq;
  logic [Q_W:0]   twice_l, dist_l;
  s1_t            s1_d, s1_q;

  always_comb begin
    lq = to_q16(lightness_i);
    sq = to_q16(saturation_i);
    // Chroma factor 1 - |2L - 1|
    twice_l = {lq, 1'b0};
    if (twice_l >= OneWide) begin
      dist_l = twice_l - OneWide;
    end else begin
      dist_l = OneWide - twice_l;
    end
    s1_d.lq   = lq;
    s1_d.sq   = sq;
    s1_d.tq   = Q_W'(OneWide - dist_l);
    // Hue numerator and reciprocal product for the divide by 15
    s1_d.num  = NUM_W'(hue_angle_i) << HueShift;
    s1_d.prod = PROD_W'(s1_d.num) * PROD_W'(RECIP_15);
  end

  // Advance when the next stage takes the item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

@@ src/hsl2rgb_chroma.sv @@
// Stage 2: chroma multiply and quotient correction for the hue divide.
module hsl2rgb_chroma import hsl2rgb_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  s1_t  s1_i,
  output s2_t  s2_o
);

  logic [2*Q_W-1:0] c_prod;
  logic [HQ_W-1:0]  q_est;
  logic [NUM_W:0]   q_times;
  logic [NUM_W:0]   rem;
  s2_t              s2_d, s2_q;

  always_comb begin
    // Chroma = tq * sq >> 16
    c_prod = (2*Q_W)'(s1_i.tq) * (2*Q_W)'(s1_i.sq);
    // Estimate is the true quotient or one below it
    q_est   = s1_i.prod[PROD_W-1:RECIP_SHIFT];
    q_times = ((NUM_W+1)'(q_est) << 4) - (NUM_W+1)'(q_est);
    rem     = {1'b0, s1_i.num} - q_times;
    s2_d.lq = s1_i.lq;
    s2_d.cq = c_prod[Q_W+15:16];
    s2_d.hq = q_est + HQ_W'(rem >= (NUM_W+1)'(HUE_DIVISOR));
  end

  // Advance when the next stage takes the item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

@@ src/hsl2rgb_mix.sv @@
// Stage 3: hue sector decode, secondary component X and lightness offset m.
module hsl2rgb_mix import hsl2rgb_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  s2_t  s2_i,
  output s3_t  s3_o
);

  logic [HQ_W-17:0]  sector_raw;
  logic [Q_W-1:0]    frac2, dist_h, wq;
  logic [2*Q_W-1:0]  x_prod;
  s3_t               s3_d, s3_q;

  always_comb begin
    // Hues past the last sector take the first sector's mapping
    sector_raw = s2_i.hq[HQ_W-1:16];
    if (sector_raw >= (HQ_W-16)'(SECTOR_COUNT)) begin
      s3_d.sector = SEC_RED_YEL;
    end else begin
      s3_d.sector = sector_e'(sector_raw[2:0]);
    end
    // Weight 1 - |H mod 2 - 1|
    frac2 = s2_i.hq[Q_W-1:0];
    if (frac2 >= ONE_Q16) begin
      dist_h = frac2 - ONE_Q16;
    end else begin
      dist_h = ONE_Q16 - frac2;
    end
    wq      = ONE_Q16 - dist_h;
    x_prod  = (2*Q_W)'(s2_i.cq) * (2*Q_W)'(wq);
    s3_d.cq = s2_i.cq;
    s3_d.xq = x_prod[Q_W+15:16];
    s3_d.mq = s2_i.lq - (s2_i.cq >> 1);
  end

  // Advance when the next stage takes the item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule

@@ src/hsl2rgb_out.sv @@
// Stage 4: channel mux, offset add, scale by 255, clamp and output registers.
module hsl2rgb_out import hsl2rgb_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  s3_t                s3_i,
  output logic [LEVEL_W-1:0] red_level_o,
  output logic [LEVEL_W-1:0] green_level_o,
  output logic [LEVEL_W-1:0] blue_level_o
);

  // (v * 255) >> 16, saturated to the 8-bit range
  function automatic logic [LEVEL_W-1:0] to_level(input logic [Q_W:0] v);
    logic [Q_W+LEVEL_W:0] scaled;
    logic [Q_W+LEVEL_W-16:0] whole;
    scaled = ((Q_W+LEVEL_W+1)'(v) << LEVEL_W) - (Q_W+LEVEL_W+1)'(v);
    whole  = scaled[Q_W+LEVEL_W:16];
    if (whole > (Q_W+LEVEL_W-15)'({LEVEL_W{1'b1}})) begin
      return {LEVEL_W{1'b1}};
    end
    return whole[LEVEL_W-1:0];
  endfunction

  logic [Q_W-1:0]     r_v, g_v, b_v;
  logic [LEVEL_W-1:0] red_d, green_d, blue_d;
  logic [LEVEL_W-1:0] red_q, green_q, blue_q;

  // Place C and X on the channels by sector
  always_comb begin
    unique case (s3_i.sector)
      SEC_YEL_GRN: begin r_v = s3_i.xq; g_v = s3_i.cq; b_v = '0;      end
      SEC_GRN_CYN: begin r_v = '0;      g_v = s3_i.cq; b_v = s3_i.xq; end
      SEC_CYN_BLU: begin r_v = '0;      g_v = s3_i.xq; b_v = s3_i.cq; end
      SEC_BLU_MAG: begin r_v = s3_i.xq; g_v = '0;      b_v = s3_i.cq; end
      SEC_MAG_RED: begin r_v = s3_i.cq; g_v = '0;      b_v = s3_i.xq; end
      default:     begin r_v = s3_i.cq; g_v = s3_i.xq; b_v = '0;      end
    endcase
    red_d   = to_level({1'b0, r_v} + {1'b0, s3_i.mq});
    green_d = to_level({1'b0, g_v} + {1'b0, s3_i.mq});
    blue_d  = to_level({1'b0, b_v} + {1'b0, s3_i.mq});
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

endmodule

@@ src/hsl_to_rgb_converter_core.sv @@
// Top level of the HSL to RGB converter: stage control and stage instances.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one HSL pixel per item:
//   hue_angle_i in degrees times 2^HUE_FRACTION_BITS, saturation_i and
//   lightness_i as 8-bit fractions of 255. Output channel
//   (out_valid_o / out_ready_i) returns one 8-bit RGB pixel per item.
//   An accepted item moves through the four register stages in order and is
//   shown on the output from the last. Throughput is one item per cycle while
//   out_ready_i is high; the four register stages (Q16 setup and hue
//   reciprocal multiply, chroma multiply and quotient correction, X multiply,
//   channel scale and clamp) each hold one item, with one valid bit per stage.
//   When the receiver holds out_ready_i low, the output register keeps its
//   item and earlier stages fill their empty slots; in_ready_o drops only
//   once all four stages hold items. Reset clears every valid bit, so the
//   block comes out of reset empty and ready. No configuration is needed.
`include "hsl_to_rgb_converter_core_defines.svh"

module hsl_to_rgb_converter_core import hsl2rgb_pkg::*; #(
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [HUE_W-1:0]   hue_angle_i,
  input  logic [LEVEL_W-1:0] saturation_i,
  input  logic [LEVEL_W-1:0] lightness_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LEVEL_W-1:0] red_level_o,
  output logic [LEVEL_W-1:0] green_level_o,
  output logic [LEVEL_W-1:0] blue_level_o
);

  localparam int unsigned Stages = 4;

  logic [Stages-1:0] valid_d, valid_q;
  logic [Stages-1:0] en;
  s1_t               s1;
  s2_t               s2;
  s3_t               s3;

  // A stage may load when it is empty or its item moves on
  always_comb begin
    en[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < Stages; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[Stages-1];

  hsl2rgb_front #(
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .en_i         (en[0]),
    .hue_angle_i  (hue_angle_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .s1_o         (s1)
  );

  hsl2rgb_chroma u_chroma (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  hsl2rgb_mix u_mix (
    .clk_i (clk_i),
    .en_i  (en[2]),
    .s2_i  (s2),
    .s3_o  (s3)
  );

  hsl2rgb_out u_out (
    .clk_i         (clk_i),
    .en_i          (en[3]),
    .s3_i          (s3),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o)
  );

  // Back pressure reaches the input only with every stage occupied
  `H2R_ASSERT(a_full_when_blocked, !in_ready_o |-> (&valid_q) && !out_ready_i)
  // An accepted item lands in the first stage
  `H2R_ASSERT(a_accept_lands, in_valid_i && in_ready_o |=> valid_q[0])
  // An item in the last compute stage moves to the output when it opens
  `H2R_ASSERT(a_stage_to_out, valid_q[2] && en[3] |=> out_valid_o)
  // Occupancy grows only through an accepted item
  `H2R_ASSERT(a_no_invented, !(in_valid_i && in_ready_o) |=> $countones(valid_q) <= $past($countones(valid_q)))
  // Reset empties the output
  `H2R_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule
